@@ src/jsu_pkg.sv @@
// Shared types, constants and helper functions of the JSON string unescaper.
package jsu_pkg;

    // Result kinds carried on the kind port.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Most results that one input byte can cause.
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    // Characters of interest.
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_FF      = 8'h0C;

    // UTF-8 encoding constants.
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [15:0] CP_ONE_MAX = 16'h0080;
    localparam logic [15:0] CP_TWO_MAX = 16'h0800;

    // Decoder mode, one-hot.
    typedef enum logic [3:0] {
        MODE_WAIT = 4'b0001,
        MODE_STR  = 4'b0010,
        MODE_ESC  = 4'b0100,
        MODE_HEX  = 4'b1000
    } mode_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } result_t;

    // All results caused by one input byte, in delivery order.
    typedef struct packed {
        logic [CNT_W-1:0]                count;
        result_t [MAX_RESULTS-1:0]       items;
    } burst_t;

    // Status of the result buffer as seen by the top level.
    typedef struct packed {
        logic empty;
        logic single;
    } buf_status_t;

    // Hex digit value: bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] diff;
        begin
            diff = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                diff = c - 8'h30;
                hex_value = {1'b1, diff[3:0]};
            end
            else if (c >= 8'h61 && c <= 8'h66) begin
                diff = c - 8'h57;
                hex_value = {1'b1, diff[3:0]};
            end
            else if (c >= 8'h41 && c <= 8'h46) begin
                diff = c - 8'h37;
                hex_value = {1'b1, diff[3:0]};
            end
            else begin
                hex_value = 5'b0_0000;
            end
        end
    endfunction

endpackage

@@ src/jsu_decode.sv @@
// Decoder state and the per-byte decode into a burst of results.
module jsu_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              end_of_buffer,
    input  logic              discard,
    output jsu_pkg::burst_t   burst
);

    jsu_pkg::mode_t mode_reg, mode_next;
    logic [1:0]     hex_cnt_reg, hex_cnt_next;
    logic [15:0]    cp_reg, cp_next;

    logic [2:0][7:0] data;
    logic [1:0]      nd_raw;
    logic [1:0]      nd;
    logic            tail_end;
    logic            tail_err;
    logic            failed;
    logic            closed;
    logic            tail;
    logic [4:0]      hv;
    logic [15:0]     cp_shift;
    logic [7:0]      esc_byte;
    logic [2:0]      n;
    logic [2:0]      n_m1;
    logic            is_ws;

    assign hv       = jsu_pkg::hex_value(data_byte);
    assign cp_shift = {cp_reg[11:0], hv[3:0]};
    assign is_ws    = (data_byte == jsu_pkg::CH_SPACE) || (data_byte == jsu_pkg::CH_TAB)
                   || (data_byte == jsu_pkg::CH_CR) || (data_byte == jsu_pkg::CH_LF);

    // Map of the single-letter escapes; anything else passes through.
    always_comb
    begin
        case (data_byte)
            jsu_pkg::CH_LOWER_N: esc_byte = jsu_pkg::CH_LF;
            jsu_pkg::CH_LOWER_T: esc_byte = jsu_pkg::CH_TAB;
            jsu_pkg::CH_LOWER_R: esc_byte = jsu_pkg::CH_CR;
            jsu_pkg::CH_LOWER_B: esc_byte = jsu_pkg::CH_BS;
            jsu_pkg::CH_LOWER_F: esc_byte = jsu_pkg::CH_FF;
            default:             esc_byte = data_byte;
        endcase
    end

    // Next state and the data bytes of this input byte.
    always_comb
    begin
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        cp_next      = cp_reg;
        data         = '0;
        nd_raw       = 2'd0;
        tail_end     = 1'b0;
        failed       = 1'b0;
        closed       = 1'b0;
        case (mode_reg)
            jsu_pkg::MODE_WAIT:
            begin
                if (data_byte == jsu_pkg::CH_QUOTE) begin
                    mode_next = jsu_pkg::MODE_STR;
                end
                else if (!is_ws) begin
                    failed = 1'b1;
                end
            end
            jsu_pkg::MODE_STR:
            begin
                if (data_byte == jsu_pkg::CH_QUOTE) begin
                    tail_end     = 1'b1;
                    closed       = 1'b1;
                    mode_next    = jsu_pkg::MODE_WAIT;
                    hex_cnt_next = 2'd0;
                    cp_next      = 16'h0000;
                end
                else if (data_byte == jsu_pkg::CH_BSLASH) begin
                    mode_next = jsu_pkg::MODE_ESC;
                end
                else begin
                    data[0] = data_byte;
                    nd_raw  = 2'd1;
                end
            end
            jsu_pkg::MODE_ESC:
            begin
                if (data_byte == jsu_pkg::CH_LOWER_U) begin
                    mode_next    = jsu_pkg::MODE_HEX;
                    hex_cnt_next = 2'd0;
                    cp_next      = 16'h0000;
                end
                else begin
                    data[0]   = esc_byte;
                    nd_raw    = 2'd1;
                    mode_next = jsu_pkg::MODE_STR;
                end
            end
            jsu_pkg::MODE_HEX:
            begin
                if (!hv[4]) begin
                    failed = 1'b1;
                end
                else if (hex_cnt_reg == 2'd3) begin
                    // Fourth digit: encode the code point as UTF-8.
                    if (cp_shift < jsu_pkg::CP_ONE_MAX) begin
                        data[0] = cp_shift[7:0];
                        nd_raw  = 2'd1;
                    end
                    else if (cp_shift < jsu_pkg::CP_TWO_MAX) begin
                        data[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, cp_shift[10:6]};
                        data[1] = jsu_pkg::UTF8_CONT | {2'b00, cp_shift[5:0]};
                        nd_raw  = 2'd2;
                    end
                    else begin
                        data[0] = jsu_pkg::UTF8_LEAD3 | {4'h0, cp_shift[15:12]};
                        data[1] = jsu_pkg::UTF8_CONT | {2'b00, cp_shift[11:6]};
                        data[2] = jsu_pkg::UTF8_CONT | {2'b00, cp_shift[5:0]};
                        nd_raw  = 2'd3;
                    end
                    mode_next    = jsu_pkg::MODE_STR;
                    hex_cnt_next = 2'd0;
                    cp_next      = 16'h0000;
                end
                else begin
                    cp_next      = cp_shift;
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                end
            end
            default:
            begin
                mode_next    = jsu_pkg::MODE_WAIT;
                hex_cnt_next = 2'd0;
                cp_next      = 16'h0000;
            end
        endcase

        // An error, or a buffer that ends with the string still open.
        tail_err = failed || (end_of_buffer && !closed);
        if (tail_err) begin
            mode_next    = jsu_pkg::MODE_WAIT;
            hex_cnt_next = 2'd0;
            cp_next      = 16'h0000;
        end
    end

    // Pack data bytes, then the end or error result, and mark the last one.
    always_comb
    begin
        nd   = discard ? 2'd0 : nd_raw;
        tail = tail_end || tail_err;
        n    = {1'b0, nd} + {2'b00, tail};
        n_m1 = n - 3'd1;
        burst       = '0;
        burst.count = n;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < nd) begin
                burst.items[i].out_byte = data[i];
                burst.items[i].kind     = jsu_pkg::KIND_DATA;
            end
        end
        if (tail) begin
            burst.items[nd].out_byte = 8'h00;
            burst.items[nd].kind     = tail_end ? jsu_pkg::KIND_END : jsu_pkg::KIND_ERR;
        end
        if (n != 3'd0) begin
            burst.items[n_m1[jsu_pkg::IDX_W-1:0]].last = 1'b1;
        end
    end

    // State registers advance once per decoded byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= jsu_pkg::MODE_WAIT;
            hex_cnt_reg <= 2'd0;
            cp_reg      <= 16'h0000;
        end
        else if (step) begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            cp_reg      <= cp_next;
        end
    end

endmodule

@@ src/jsu_result_buf.sv @@
// Result register: holds one burst of results and hands them out one beat at a time.
module jsu_result_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  jsu_pkg::burst_t       burst,
    input  logic                  pop,
    output logic                  out_valid,
    output jsu_pkg::result_t      head,
    output jsu_pkg::buf_status_t  status
);

    logic [jsu_pkg::CNT_W-1:0]                  count_reg, count_next;
    jsu_pkg::result_t [jsu_pkg::MAX_RESULTS-1:0] items_reg, items_next;

    assign out_valid     = (count_reg != '0);
    assign head          = items_reg[0];
    assign status.empty  = (count_reg == '0);
    assign status.single = (count_reg == jsu_pkg::CNT_W'(1));

    // A load replaces the contents; a delivered beat shifts the rest forward.
    always_comb
    begin
        count_next = count_reg;
        items_next = items_reg;
        if (load) begin
            count_next = burst.count;
            items_next = burst.items;
        end
        else if (pop && out_valid) begin
            count_next = count_reg - jsu_pkg::CNT_W'(1);
            for (int i = 0; i < jsu_pkg::MAX_RESULTS - 1; i++) begin
                items_next[i] = items_reg[i + 1];
            end
            items_next[jsu_pkg::MAX_RESULTS-1] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end
        else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        items_reg <= items_next;
    end

endmodule

@@ src/json_string_unescape.sv @@
// Top level of the JSON string unescaper: input register, decoder and result register.
//
// The block takes one raw text byte per input beat (data_byte, end_of_buffer,
// discard) on a valid/ready channel and gives decoded results, one per output
// beat, on a second valid/ready channel (out_byte, kind, last). Each input byte
// causes zero to four results; last marks the final result of one input byte.
// An accepted byte is held in the input register, decoded there, and its results
// are loaded into the result register, from which the first result is offered.
// Throughput is one input byte per cycle while every byte causes at most one
// result and the receiver is ready; a byte that causes more results holds up the
// next byte while the single-beat output port drains the result register.
// When the receiver stalls, the result register holds and the input register
// fills, after which in_ready falls until the result register drains.
// Reset clears both registers and puts the decoder back to waiting for an
// opening quote.
module json_string_unescape (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_buffer,
    input  logic       discard,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic       last
);

    logic                 in_valid_reg;
    logic [7:0]           data_reg;
    logic                 eob_reg;
    logic                 discard_reg;
    logic                 move;
    jsu_pkg::burst_t      burst;
    jsu_pkg::result_t     head;
    jsu_pkg::buf_status_t status;

    // The held byte moves on once the result register is free or about to be.
    assign move     = in_valid_reg && (status.empty || (status.single && out_ready));
    assign in_ready = !in_valid_reg || move;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            data_reg    <= data_byte;
            eob_reg     <= end_of_buffer;
            discard_reg <= discard;
        end
    end

    jsu_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (move),
        .data_byte     (data_reg),
        .end_of_buffer (eob_reg),
        .discard       (discard_reg),
        .burst         (burst)
    );

    jsu_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (move),
        .burst     (burst),
        .pop       (out_ready),
        .out_valid (out_valid),
        .head      (head),
        .status    (status)
    );

    assign out_byte = head.out_byte;
    assign kind     = head.kind;
    assign last     = head.last;

    // A held byte that cannot move keeps its contents.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !move |=> in_valid_reg && $stable(data_reg))
        else $error("input register lost a byte while blocked");

    // End and error results carry a zero byte.
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != jsu_pkg::KIND_DATA) |-> out_byte == 8'h00)
        else $error("non-data result with a non-zero byte");

    // Only the three defined kinds leave the block.
    a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == jsu_pkg::KIND_DATA) || (kind == jsu_pkg::KIND_END)
                   || (kind == jsu_pkg::KIND_ERR))
        else $error("undefined result kind");

    // Once the final result of a byte is taken and nothing new is loaded, output goes idle.
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last && !move |=> !out_valid)
        else $error("results remain after the last beat of a byte");

endmodule

@@ bench/json_string_unescape_checker.sv @@
// Checker for the JSON string unescaper: decodes accepted bytes and compares result beats.
module json_string_unescape_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_buffer,
    input  logic       discard,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic [1:0] kind,
    input  logic       last,
    output int         fail_count,
    output int         pending
);

    // Decoder position within the text.
    typedef enum logic [3:0] {
        AWAIT_QUOTE  = 4'b0001,
        IN_STRING    = 4'b0010,
        AFTER_BSLASH = 4'b0100,
        IN_HEX       = 4'b1000
    } dec_mode_t;

    dec_mode_t   dec_mode;
    logic [1:0]  hex_count;
    logic [15:0] cp_acc;

    // Decoded beats not yet seen on the output, oldest first.
    jsu_pkg::result_t decoded_queue[$];

    function automatic jsu_pkg::result_t make_beat(input logic [7:0] b, input logic [1:0] k);
        jsu_pkg::result_t r;
        r.out_byte = b;
        r.kind     = k;
        r.last     = 1'b0;
        return r;
    endfunction

    // Work out every result beat that one raw byte causes and queue them.
    task automatic decode_byte(input logic [7:0] c, input logic eob, input logic disc);
        jsu_pkg::result_t burst[$];
        logic             closed;
        logic             failed;
        logic             nib_ok;
        logic [7:0]       nib;
        logic [7:0]       esc_out;
        logic [15:0]      cp;
        closed = 1'b0;
        failed = 1'b0;
        nib_ok = 1'b0;
        nib    = 8'h00;
        cp     = 16'h0000;
        case (dec_mode)
            AWAIT_QUOTE:
            begin
                if (c == jsu_pkg::CH_QUOTE)
                    dec_mode = IN_STRING;
                else if (c != jsu_pkg::CH_SPACE && c != jsu_pkg::CH_TAB
                         && c != jsu_pkg::CH_CR && c != jsu_pkg::CH_LF)
                    failed = 1'b1;
            end
            IN_STRING:
            begin
                if (c == jsu_pkg::CH_QUOTE)
                begin
                    burst     = {burst, make_beat(8'h00, jsu_pkg::KIND_END)};
                    closed    = 1'b1;
                    dec_mode  = AWAIT_QUOTE;
                    hex_count = 2'd0;
                    cp_acc    = 16'd0;
                end
                else if (c == jsu_pkg::CH_BSLASH)
                    dec_mode = AFTER_BSLASH;
                else if (!disc)
                    burst = {burst, make_beat(c, jsu_pkg::KIND_DATA)};
            end
            AFTER_BSLASH:
            begin
                if (c == jsu_pkg::CH_LOWER_U)
                begin
                    dec_mode  = IN_HEX;
                    hex_count = 2'd0;
                    cp_acc    = 16'd0;
                end
                else
                begin
                    case (c)
                        jsu_pkg::CH_LOWER_N: esc_out = jsu_pkg::CH_LF;
                        jsu_pkg::CH_LOWER_T: esc_out = jsu_pkg::CH_TAB;
                        jsu_pkg::CH_LOWER_R: esc_out = jsu_pkg::CH_CR;
                        jsu_pkg::CH_LOWER_B: esc_out = jsu_pkg::CH_BS;
                        jsu_pkg::CH_LOWER_F: esc_out = jsu_pkg::CH_FF;
                        default:             esc_out = c;
                    endcase
                    if (!disc)
                        burst = {burst, make_beat(esc_out, jsu_pkg::KIND_DATA)};
                    dec_mode = IN_STRING;
                end
            end
            default:
            begin
                // Hex digit value, either case.
                if (c >= 8'h30 && c <= 8'h39)
                begin
                    nib    = c - 8'h30;
                    nib_ok = 1'b1;
                end
                else if (c >= 8'h61 && c <= 8'h66)
                begin
                    nib    = c - 8'h57;
                    nib_ok = 1'b1;
                end
                else if (c >= 8'h41 && c <= 8'h46)
                begin
                    nib    = c - 8'h37;
                    nib_ok = 1'b1;
                end
                if (!nib_ok)
                    failed = 1'b1;
                else
                begin
                    cp     = {cp_acc[11:0], nib[3:0]};
                    cp_acc = cp;
                    if (hex_count == 2'd3)
                    begin
                        // Fourth digit: emit the code point as UTF-8.
                        if (!disc)
                        begin
                            if (cp < jsu_pkg::CP_ONE_MAX)
                                burst = {burst, make_beat(cp[7:0], jsu_pkg::KIND_DATA)};
                            else if (cp < jsu_pkg::CP_TWO_MAX)
                            begin
                                burst = {burst,
                                         make_beat(jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]},
                                                   jsu_pkg::KIND_DATA)};
                                burst = {burst,
                                         make_beat(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]},
                                                   jsu_pkg::KIND_DATA)};
                            end
                            else
                            begin
                                burst = {burst,
                                         make_beat(jsu_pkg::UTF8_LEAD3 | {4'h0, cp[15:12]},
                                                   jsu_pkg::KIND_DATA)};
                                burst = {burst,
                                         make_beat(jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]},
                                                   jsu_pkg::KIND_DATA)};
                                burst = {burst,
                                         make_beat(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]},
                                                   jsu_pkg::KIND_DATA)};
                            end
                        end
                        dec_mode  = IN_STRING;
                        hex_count = 2'd0;
                        cp_acc    = 16'd0;
                    end
                    else
                        hex_count = hex_count + 2'd1;
                end
            end
        endcase

        // A bad byte, or the buffer ending before the string closes, adds an error.
        if (failed || (eob && !closed))
        begin
            burst     = {burst, make_beat(8'h00, jsu_pkg::KIND_ERR)};
            dec_mode  = AWAIT_QUOTE;
            hex_count = 2'd0;
            cp_acc    = 16'd0;
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        decoded_queue = {decoded_queue, burst};
    endtask

    // Watch both channels at each rising edge.
    always @(posedge clk)
    begin
        jsu_pkg::result_t want;
        if (!rst_n)
        begin
            dec_mode   = AWAIT_QUOTE;
            hex_count  = 2'd0;
            cp_acc     = 16'd0;
            decoded_queue.delete();
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                decode_byte(data_byte, end_of_buffer, discard);
            if (out_valid && out_ready)
            begin
                if (decoded_queue.size() == 0)
                begin
                    $error("result beat with nothing expected: out_byte %0h kind %0d last %0d",
                           out_byte, kind, last);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = decoded_queue.pop_front();
                    if (out_byte !== want.out_byte || kind !== want.kind
                        || last !== want.last)
                        fail_count <= fail_count + 1;
                    if (out_byte !== want.out_byte)
                        $error("out_byte: expected %0h, actual %0h", want.out_byte, out_byte);
                    if (kind !== want.kind)
                        $error("kind: expected %0d, actual %0d", want.kind, kind);
                    if (last !== want.last)
                        $error("last: expected %0d, actual %0d", want.last, last);
                end
            end
        end
        pending <= decoded_queue.size();
    end

endmodule

@@ bench/json_string_unescape_tb.sv @@
// Testbench top for the JSON string unescaper: clock, reset, byte stimulus and verdict.
module json_string_unescape_tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 260;
    localparam int PHASES        = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;
    logic       discard;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int sent_count  = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_go       = 1'b0;
    bit hold_taken    = 1'b0;
    int hold_left     = 0;

    json_string_unescape i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .discard       (discard),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .kind          (kind),
        .last          (last)
    );

    json_string_unescape_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .discard       (discard),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .kind          (kind),
        .last          (last),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Free-running clock, period of two units.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left  = hold_left - 1;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one input beat, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_byte(input logic [7:0] b, input logic eob, input logic disc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_buffer <= eob;
        discard       <= disc;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count = sent_count + 1;
        @(negedge clk);
    endtask

    // Stop offering and wait until every expected beat has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10)
            return 8'h30 + {4'h0, nib};
        return (upper ? 8'h37 : 8'h57) + {4'h0, nib};
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(3))
            0:       return jsu_pkg::CH_SPACE;
            1:       return jsu_pkg::CH_TAB;
            2:       return jsu_pkg::CH_CR;
            default: return jsu_pkg::CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_bad_hex();
        case ($urandom_range(9))
            0:       return 8'h2F;
            1:       return 8'h3A;
            2:       return 8'h40;
            3:       return 8'h47;
            4:       return 8'h60;
            5:       return 8'h67;
            6:       return 8'h00;
            7:       return 8'hFF;
            8:       return jsu_pkg::CH_QUOTE;
            default: return jsu_pkg::CH_BSLASH;
        endcase
    endfunction

    // A well-formed string with random content: ordinary bytes, escapes and code points.
    task automatic send_good_string();
        logic        disc;
        logic        eob_end;
        logic [7:0]  b;
        logic [15:0] cp;
        int          parts;
        disc    = ($urandom_range(3) == 0);
        eob_end = ($urandom_range(3) == 0);
        repeat ($urandom_range(2))
            send_byte(pick_space(), 1'b0, disc);
        send_byte(jsu_pkg::CH_QUOTE, 1'b0, disc);
        parts = $urandom_range(6);
        repeat (parts)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    b = 8'($urandom_range(255));
                    if (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH)
                        b = 8'h61;
                    send_byte(b, 1'b0, disc ^ ($urandom_range(15) == 0));
                end
                4, 5, 6:
                begin
                    send_byte(jsu_pkg::CH_BSLASH, 1'b0, disc);
                    case ($urandom_range(8))
                        0:       b = jsu_pkg::CH_LOWER_N;
                        1:       b = jsu_pkg::CH_LOWER_T;
                        2:       b = jsu_pkg::CH_LOWER_R;
                        3:       b = jsu_pkg::CH_LOWER_B;
                        4:       b = jsu_pkg::CH_LOWER_F;
                        5:       b = jsu_pkg::CH_QUOTE;
                        6:       b = jsu_pkg::CH_BSLASH;
                        7:       b = 8'h2F;
                        default: b = 8'($urandom_range(255));
                    endcase
                    if (b == jsu_pkg::CH_LOWER_U)
                        b = 8'h2F;
                    send_byte(b, 1'b0, disc ^ ($urandom_range(15) == 0));
                end
                default:
                begin
                    // Code point in the one, two or three byte range.
                    case ($urandom_range(2))
                        0:       cp = 16'($urandom_range(16'h007F));
                        1:       cp = 16'($urandom_range(16'h07FF, 16'h0080));
                        default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
                    endcase
                    send_byte(jsu_pkg::CH_BSLASH, 1'b0, disc);
                    send_byte(jsu_pkg::CH_LOWER_U, 1'b0, disc);
                    send_byte(hex_char(cp[15:12], 1'($urandom_range(1))), 1'b0, disc);
                    send_byte(hex_char(cp[11:8], 1'($urandom_range(1))), 1'b0, disc);
                    send_byte(hex_char(cp[7:4], 1'($urandom_range(1))), 1'b0, disc);
                    send_byte(hex_char(cp[3:0], 1'($urandom_range(1))), 1'b0,
                              disc ^ ($urandom_range(15) == 0));
                end
            endcase
        end
        send_byte(jsu_pkg::CH_QUOTE, eob_end, disc);
    endtask

    // Noise and broken strings: junk while waiting, early buffer end, bad hex digit.
    task automatic send_bad_string();
        logic disc;
        int   digits;
        disc = 1'($urandom_range(1));
        case ($urandom_range(3))
            0:
            begin
                repeat ($urandom_range(3, 1))
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
            end
            1:
            begin
                send_byte(jsu_pkg::CH_QUOTE, 1'b0, disc);
                repeat ($urandom_range(3))
                    send_byte(8'h41 + 8'($urandom_range(25)), 1'b0, disc);
                send_byte(8'h30 + 8'($urandom_range(9)), 1'b1, disc);
            end
            2:
            begin
                send_byte(jsu_pkg::CH_QUOTE, 1'b0, disc);
                send_byte(jsu_pkg::CH_BSLASH, 1'b0, disc);
                send_byte(jsu_pkg::CH_LOWER_U, 1'b0, disc);
                digits = $urandom_range(3);
                repeat (digits)
                    send_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))),
                              1'b0, disc);
                send_byte(pick_bad_hex(), 1'($urandom_range(1)), disc);
            end
            default:
            begin
                // Buffer ends right after a backslash or part way through hex digits.
                send_byte(jsu_pkg::CH_QUOTE, 1'b0, disc);
                send_byte(jsu_pkg::CH_BSLASH, ($urandom_range(1) == 0), disc);
                if (end_of_buffer == 1'b0)
                begin
                    send_byte(jsu_pkg::CH_LOWER_U, 1'b0, disc);
                    send_byte(hex_char(4'($urandom_range(15)), 1'b0), 1'b1, disc);
                end
            end
        endcase
    endtask

    // Reset, directed beats, then random phases with differing idling.
    initial
    begin
        int target;
        in_valid      = 1'b0;
        data_byte     = 8'h00;
        end_of_buffer = 1'b0;
        discard       = 1'b0;
        rst_n         = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Whitespace skipped while waiting, then a stray byte there.
        send_byte(jsu_pkg::CH_SPACE, 1'b0, 1'b0);
        send_byte(jsu_pkg::CH_TAB, 1'b0, 1'b0);
        send_byte(jsu_pkg::CH_CR, 1'b0, 1'b0);
        send_byte(jsu_pkg::CH_LF, 1'b0, 1'b0);
        send_byte(8'h78, 1'b0, 1'b0);
        // Buffer ending on the opening quote.
        send_byte(jsu_pkg::CH_QUOTE, 1'b1, 1'b0);
        // Data extremes, the upper one under discard.
        send_byte(jsu_pkg::CH_QUOTE, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        // Every named escape.
        send_byte(jsu_pkg::CH_BSLASH, 1'b0, 1'b0);
        send_byte(jsu_pkg::CH_LOWER_N, 1'b0, 1'b0);
        send_byte(jsu_pkg::CH_BSLASH, 1'b0, 1'b0);
        send_byte(jsu_pkg::CH_LOWER_T, 1'b0, 1'b0);
        send_byte(jsu_pkg::CH_BSLASH, 1'b0, 1'b0);
        send_byte(jsu_pkg::CH_LOWER_R, 1'b0, 1'b0);
        send_byte(jsu_pkg::CH_BSLASH, 1'b0, 1'b0);
        send_byte(jsu_pkg::CH_LOWER_B, 1'b0, 1'b0);
        send_byte(jsu_pkg::CH_BSLASH, 1'b0, 1'b0);
        send_byte(jsu_pkg::CH_LOWER_F, 1'b0, 1'b0);
        // Largest code point, digits in mixed case.
        send_byte(jsu_pkg::CH_BSLASH, 1'b0, 1'b0);
        send_byte(jsu_pkg::CH_LOWER_U, 1'b0, 1'b0);
        send_byte(8'h46, 1'b0, 1'b0);
        send_byte(8'h66, 1'b0, 1'b0);
        send_byte(8'h46, 1'b0, 1'b0);
        send_byte(8'h66, 1'b0, 1'b0);
        // Closing quote on the last byte of the buffer.
        send_byte(jsu_pkg::CH_QUOTE, 1'b1, 1'b0);
        // Bad hex digit just past the digit range.
        send_byte(jsu_pkg::CH_QUOTE, 1'b0, 1'b0);
        send_byte(jsu_pkg::CH_BSLASH, 1'b0, 1'b0);
        send_byte(jsu_pkg::CH_LOWER_U, 1'b0, 1'b0);
        send_byte(8'h67, 1'b0, 1'b0);
        wait_drained();

        // Random phases: none (with the one long receiver hold-off), sender idle, receiver stalling, both.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    hold_go       = 1'b1;
                end
                1:
                begin
                    send_idle_pct = 68;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 68;
                end
                default:
                begin
                    send_idle_pct = 19;
                    stall_pct     = 19;
                end
            endcase
            target = sent_count + RANDOM_ITEMS / PHASES;
            while (sent_count < target)
            begin
                if ($urandom_range(4) == 0)
                    send_bad_string();
                else
                    send_good_string();
            end
            wait_drained();
        end

        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
src/jsu_pkg.sv
src/jsu_decode.sv
src/jsu_result_buf.sv
src/json_string_unescape.sv
bench/json_string_unescape_checker.sv
bench/json_string_unescape_tb.sv
